FILE: src/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
package hsv2rgb_pkg;

	localparam int unsigned HUE_W   = 16;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned SCALE_W = 11;

	localparam logic [SCALE_W-1:0] HUE_SPAN  = 11'd1530;
	localparam logic [15:0]        HUE_ROUND = 16'd32768;
	localparam logic [SCALE_W-1:0] SECT_1    = 11'd255;
	localparam logic [SCALE_W-1:0] SECT_2    = 11'd510;
	localparam logic [SCALE_W-1:0] SECT_3    = 11'd765;
	localparam logic [SCALE_W-1:0] SECT_4    = 11'd1020;
	localparam logic [SCALE_W-1:0] SECT_5    = 11'd1275;
	localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'd255;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

endpackage

FILE: src/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB converter.
// Converts one pixel per clock. A request is taken whenever start is high; busy
// is always low. The result appears on red_out, green_out and blue_out with done
// high for one cycle, after the request has passed through the four register
// stages: hue rescale, sector levels, saturation blend and value scaling, each built
// around one multiplier or compare chain; results cannot be held off.
module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [HUE_W-1:0]  hue_in,
	input  logic [CHAN_W-1:0] saturation_in,
	input  logic [CHAN_W-1:0] value_in,
	output logic              done,
	output logic [CHAN_W-1:0] red_out,
	output logic [CHAN_W-1:0] green_out,
	output logic [CHAN_W-1:0] blue_out
);

	logic              lvl_valid;
	rgb_t              level;
	logic [CHAN_W-1:0] sat_lvl;
	logic [CHAN_W-1:0] val_lvl;
	logic              valid_s3;
	logic              valid_s4;

	assign busy = 1'b0;

	hsv2rgb_hue u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.hue       (hue_in),
		.sat       (saturation_in),
		.val       (value_in),
		.out_valid (lvl_valid),
		.level     (level),
		.sat_out   (sat_lvl),
		.val_out   (val_lvl)
	);

	hsv2rgb_shade u_red (
		.clk   (clk),
		.level (level.r),
		.sat   (sat_lvl),
		.val   (val_lvl),
		.chan  (red_out)
	);

	hsv2rgb_shade u_green (
		.clk   (clk),
		.level (level.g),
		.sat   (sat_lvl),
		.val   (val_lvl),
		.chan  (green_out)
	);

	hsv2rgb_shade u_blue (
		.clk   (clk),
		.level (level.b),
		.sat   (sat_lvl),
		.val   (val_lvl),
		.chan  (blue_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= lvl_valid;
			valid_s4 <= valid_s3;
		end
	end

	assign done = valid_s4;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without a request four cycles earlier");

	a_black_on_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(value_in, 4) == '0) |->
			(red_out == '0 && green_out == '0 && blue_out == '0))
		else $error("zero value did not give black");

endmodule

FILE: src/hsv2rgb_hue.sv
// Hue rescale and six-sector pure-hue level stages.
module hsv2rgb_hue
	import hsv2rgb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [HUE_W-1:0]  hue,
	input  logic [CHAN_W-1:0] sat,
	input  logic [CHAN_W-1:0] val,
	output logic              out_valid,
	output rgb_t              level,
	output logic [CHAN_W-1:0] sat_out,
	output logic [CHAN_W-1:0] val_out
);

	logic                valid_s1;
	logic                valid_s2;
	logic [26:0]         scaled;
	logic [SCALE_W-1:0]  h_s1;
	logic [CHAN_W-1:0]   sat_s1;
	logic [CHAN_W-1:0]   val_s1;
	rgb_t                lvl;
	rgb_t                lvl_s2;
	logic [CHAN_W-1:0]   sat_s2;
	logic [CHAN_W-1:0]   val_s2;
	logic [SCALE_W-1:0]  diff;

	assign scaled = 27'(hue) * 27'(HUE_SPAN) + 27'(HUE_ROUND);

	always_comb begin
		lvl  = '{r: CHAN_MAX, g: '0, b: '0};
		diff = '0;
		if (h_s1 < SECT_2) begin
			if (h_s1 < SECT_1) begin
				lvl = '{r: CHAN_MAX, g: h_s1[CHAN_W-1:0], b: '0};
			end else begin
				diff = SECT_2 - h_s1;
				lvl  = '{r: diff[CHAN_W-1:0], g: CHAN_MAX, b: '0};
			end
		end else if (h_s1 < SECT_4) begin
			if (h_s1 < SECT_3) begin
				diff = h_s1 - SECT_2;
				lvl  = '{r: '0, g: CHAN_MAX, b: diff[CHAN_W-1:0]};
			end else begin
				diff = SECT_4 - h_s1;
				lvl  = '{r: '0, g: diff[CHAN_W-1:0], b: CHAN_MAX};
			end
		end else if (h_s1 < HUE_SPAN) begin
			if (h_s1 < SECT_5) begin
				diff = h_s1 - SECT_4;
				lvl  = '{r: diff[CHAN_W-1:0], g: '0, b: CHAN_MAX};
			end else begin
				diff = HUE_SPAN - h_s1;
				lvl  = '{r: CHAN_MAX, g: '0, b: diff[CHAN_W-1:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		h_s1   <= scaled[26:16];
		sat_s1 <= sat;
		val_s1 <= val;
		lvl_s2 <= lvl;
		sat_s2 <= sat_s1;
		val_s2 <= val_s1;
	end

	assign out_valid = valid_s2;
	assign level     = lvl_s2;
	assign sat_out   = sat_s2;
	assign val_out   = val_s2;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> h_s1 <= HUE_SPAN)
		else $error("scaled hue out of range");

	a_pure_hue: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (lvl_s2.r == CHAN_MAX || lvl_s2.g == CHAN_MAX || lvl_s2.b == CHAN_MAX)
			&& (lvl_s2.r == '0 || lvl_s2.g == '0 || lvl_s2.b == '0))
		else $error("pure-hue level lacks a full or an empty channel");

endmodule

FILE: src/hsv2rgb_shade.sv
// One channel lane: saturation blend, then value scaling.
module hsv2rgb_shade
	import hsv2rgb_pkg::*;
(
	input  logic              clk,
	input  logic [CHAN_W-1:0] level,
	input  logic [CHAN_W-1:0] sat,
	input  logic [CHAN_W-1:0] val,
	output logic [CHAN_W-1:0] chan
);

	logic [16:0]       blend;
	logic [8:0]        sum;
	logic [CHAN_W-1:0] sum_s3;
	logic [CHAN_W-1:0] val_s3;
	logic [16:0]       prod;
	logic [CHAN_W-1:0] chan_s4;

	assign blend = 17'(level) * (17'(sat) + 17'd1);
	assign sum   = blend[16:8] + 9'(CHAN_MAX - sat);
	assign prod  = 17'(sum_s3) * (17'(val_s3) + 17'd1);

	always_ff @(posedge clk) begin
		sum_s3  <= sum[CHAN_W-1:0];
		val_s3  <= val;
		chan_s4 <= prod[15:8];
	end

	assign chan = chan_s4;

endmodule
